// ----- hw/rtl/infix_to_postfix_converter_unit_defines.svh -----
// Assertion macros shared by the infix-to-postfix RTL.
// No dependencies; the including module must provide clk and rst_n.
`ifndef INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH
`define INFIX_TO_POSTFIX_CONVERTER_UNIT_DEFINES_SVH

// Checked only outside reset.
`define ITP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ITP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hw/rtl/itp_pkg.sv -----
// Types, character codes and priority function for the infix-to-postfix unit.
// No dependencies.
package itp_pkg;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_DIG_0 = 8'h30;
  localparam logic [7:0] CH_DIG_9 = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;

  localparam logic [1:0] PRIO_NONE = 2'd0;
  localparam logic [1:0] PRIO_ADD  = 2'd1;
  localparam logic [1:0] PRIO_MUL  = 2'd2;

  typedef struct packed {
    logic       blank;
    logic       alnum;
    logic       open;
    logic       close;
    logic [1:0] prio;
  } itp_class_t;

  function automatic logic [1:0] prio_of(input logic [7:0] c);
    logic [1:0] p;
    p = PRIO_NONE;
    if (c == CH_PLUS || c == CH_MINUS) p = PRIO_ADD;
    else if (c == CH_STAR || c == CH_SLASH) p = PRIO_MUL;
    return p;
  endfunction

endpackage

// ----- hw/rtl/itp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module itp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/itp_classify.sv -----
// Character classifier: whitespace, alphanumeric, parentheses, operator priority.
// Depends on itp_pkg.
module itp_classify (
  input  logic [7:0]         ch,
  output itp_pkg::itp_class_t cls
);

  always_comb begin
    cls.blank = (ch == itp_pkg::CH_SPACE) ||
                (ch >= itp_pkg::CH_TAB && ch <= itp_pkg::CH_CR);
    cls.alnum = (ch >= itp_pkg::CH_DIG_0 && ch <= itp_pkg::CH_DIG_9) ||
                (ch >= itp_pkg::CH_UP_A && ch <= itp_pkg::CH_UP_Z) ||
                (ch >= itp_pkg::CH_LO_A && ch <= itp_pkg::CH_LO_Z);
    cls.open  = (ch == itp_pkg::CH_OPEN);
    cls.close = (ch == itp_pkg::CH_CLOSE);
    cls.prio  = itp_pkg::prio_of(ch);
  end

endmodule

// ----- hw/rtl/infix_to_postfix_converter_unit.sv -----
// Shunting-yard infix-to-postfix converter: sequencer, operator stack RAM, output register.
// Depends on itp_pkg, itp_ram, itp_classify and the assertion macro header.
//
//  channel | ports                                         | dir | handshake
//  --------+-----------------------------------------------+-----+----------------------
//  in      | in_char, in_end_of_expression                 | in  | in_valid / in_ready
//  out     | out_char, out_char_valid, out_overflow, out_last | out | out_valid / out_ready
//
// After acceptance the item is dispatched: a blank goes straight to finish, an operand to put,
// '(' to push, ')' and any other operator to stack reads; a dropped push emits an overflow word,
// and each popped operator takes a read address, read data and result step through the single
// registered read port of the RAM. A flush on the final character pops every entry on the stack.
// in_ready is high only while the sequencer is idle; one result word sits in a holding
// register so the last mark can be set once the item is known to produce nothing more.
// Reset empties the stack at once; stack contents need no clearing.
// out_ready low stalls the sequencer only when a new result must pass the output register.
`include "infix_to_postfix_converter_unit_defines.svh"

module infix_to_postfix_converter_unit #(
  parameter int STACK_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char,
  input  logic       in_end_of_expression,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_char_valid,
  output logic       out_overflow,
  output logic       out_last
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISPATCH = 4'd1;
  localparam logic [3:0] S_RD       = 4'd2;
  localparam logic [3:0] S_RWAIT    = 4'd3;
  localparam logic [3:0] S_PUSH     = 4'd4;
  localparam logic [3:0] S_PUT      = 4'd5;
  localparam logic [3:0] S_FIN      = 4'd6;
  localparam logic [3:0] S_END      = 4'd7;

  localparam logic [1:0] MODE_OP    = 2'd0;
  localparam logic [1:0] MODE_CLOSE = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  logic [3:0]    state_r, state_nxt;
  logic [3:0]    ret_r, ret_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [7:0]    char_r, char_nxt;
  logic          fin_r, fin_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] cnt_dec;

  logic [7:0]    res_char_r, res_char_nxt;
  logic          res_vld_r, res_vld_nxt;
  logic          res_ovf_r, res_ovf_nxt;

  logic [7:0]    hold_char_r, hold_char_nxt;
  logic          hold_vld_r, hold_vld_nxt;
  logic          hold_ovf_r, hold_ovf_nxt;
  logic          hold_v_r, hold_v_nxt;

  logic          out_valid_r;
  logic [7:0]    out_char_r;
  logic          out_char_valid_r;
  logic          out_overflow_r;
  logic          out_last_r;
  logic          out_load;
  logic          out_last_sel;
  logic          out_can;

  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic          nonempty;
  logic          full;

  itp_pkg::itp_class_t char_cls;
  itp_pkg::itp_class_t top_cls;

  itp_classify u_cls_char (.ch(char_r),    .cls(char_cls));
  itp_classify u_cls_top  (.ch(ram_rdata), .cls(top_cls));

  assign cnt_dec = count_r - CW'(1);

  itp_ram #(
    .WIDTH(8),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   (ram_we),
    .waddr(count_r[AW-1:0]),
    .wdata(char_r),
    .raddr(cnt_dec[AW-1:0]),
    .rdata(ram_rdata)
  );

  assign nonempty = (count_r != '0);
  assign full     = (count_r == CW'(STACK_DEPTH));
  assign out_can  = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    mode_nxt      = mode_r;
    char_nxt      = char_r;
    fin_nxt       = fin_r;
    count_nxt     = count_r;
    res_char_nxt  = res_char_r;
    res_vld_nxt   = res_vld_r;
    res_ovf_nxt   = res_ovf_r;
    hold_char_nxt = hold_char_r;
    hold_vld_nxt  = hold_vld_r;
    hold_ovf_nxt  = hold_ovf_r;
    hold_v_nxt    = hold_v_r;
    out_load      = 1'b0;
    out_last_sel  = 1'b0;
    ram_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          char_nxt  = in_char;
          fin_nxt   = in_end_of_expression;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (char_cls.blank) begin
          state_nxt = S_FIN;
        end else if (char_cls.alnum) begin
          res_char_nxt = char_r;
          res_vld_nxt  = 1'b1;
          res_ovf_nxt  = 1'b0;
          ret_nxt      = S_FIN;
          state_nxt    = S_PUT;
        end else if (char_cls.open) begin
          state_nxt = S_PUSH;
        end else if (char_cls.close) begin
          mode_nxt  = MODE_CLOSE;
          state_nxt = S_RD;
        end else begin
          mode_nxt  = MODE_OP;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        // top of stack is on ram_rdata now
        case (mode_r)
          MODE_OP: begin
            if (nonempty && (top_cls.prio >= char_cls.prio)) begin
              count_nxt    = cnt_dec;
              res_char_nxt = ram_rdata;
              res_vld_nxt  = 1'b1;
              res_ovf_nxt  = 1'b0;
              ret_nxt      = S_RD;
              state_nxt    = S_PUT;
            end else begin
              state_nxt = S_PUSH;
            end
          end
          MODE_CLOSE: begin
            if (nonempty && !top_cls.open) begin
              count_nxt    = cnt_dec;
              res_char_nxt = ram_rdata;
              res_vld_nxt  = 1'b1;
              res_ovf_nxt  = 1'b0;
              ret_nxt      = S_RD;
              state_nxt    = S_PUT;
            end else begin
              if (nonempty) count_nxt = cnt_dec;  // drop the matching '('
              state_nxt = S_FIN;
            end
          end
          default: begin
            if (nonempty) begin
              count_nxt    = cnt_dec;
              res_char_nxt = ram_rdata;
              res_vld_nxt  = 1'b1;
              res_ovf_nxt  = 1'b0;
              ret_nxt      = S_RD;
              state_nxt    = S_PUT;
            end else begin
              state_nxt = S_END;
            end
          end
        endcase
      end
      S_PUSH: begin
        if (full) begin
          res_char_nxt = '0;
          res_vld_nxt  = 1'b0;
          res_ovf_nxt  = 1'b1;
          ret_nxt      = S_FIN;
          state_nxt    = S_PUT;
        end else begin
          ram_we    = 1'b1;
          count_nxt = count_r + CW'(1);
          state_nxt = S_FIN;
        end
      end
      S_PUT: begin
        // previous held word goes out before the new one takes its place
        if (!hold_v_r || out_can) begin
          out_load      = hold_v_r;
          hold_char_nxt = res_char_r;
          hold_vld_nxt  = res_vld_r;
          hold_ovf_nxt  = res_ovf_r;
          hold_v_nxt    = 1'b1;
          state_nxt     = ret_r;
        end
      end
      S_FIN: begin
        if (fin_r) begin
          mode_nxt  = MODE_FLUSH;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (!fin_r && !hold_v_r) begin
          state_nxt = S_IDLE;
        end else if (out_can) begin
          out_load     = 1'b1;
          out_last_sel = fin_r;
          hold_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      hold_v_r <= hold_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ret_r       <= ret_nxt;
    mode_r      <= mode_nxt;
    char_r      <= char_nxt;
    fin_r       <= fin_nxt;
    res_char_r  <= res_char_nxt;
    res_vld_r   <= res_vld_nxt;
    res_ovf_r   <= res_ovf_nxt;
    hold_char_r <= hold_char_nxt;
    hold_vld_r  <= hold_vld_nxt;
    hold_ovf_r  <= hold_ovf_nxt;
    if (out_load) begin
      // empty word with the last mark when nothing is held
      out_char_r       <= hold_v_r ? hold_char_r : '0;
      out_char_valid_r <= hold_v_r & hold_vld_r;
      out_overflow_r   <= hold_v_r & hold_ovf_r;
      out_last_r       <= out_last_sel;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char       = out_char_r;
  assign out_char_valid = out_char_valid_r;
  assign out_overflow   = out_overflow_r;
  assign out_last       = out_last_r;

  `ITP_ASSERT(a_count_range, count_r <= CW'(STACK_DEPTH), "stack count above depth")
  `ITP_ASSERT(a_push_room, ram_we |-> !full, "push into a full stack")
  `ITP_ASSERT(a_idle_no_hold, (state_r == S_IDLE) |-> !hold_v_r, "held word left at idle")
  `ITP_ASSERT(a_flush_empty, (state_r == S_END && fin_r) |-> !nonempty, "stack left after flush")
  `ITP_ASSERT(a_accept_dispatch, (in_valid && in_ready) |=> (state_r == S_DISPATCH), "no dispatch")

endmodule

// ----- tb/infix_to_postfix_converter_unit_tb.sv -----
// Self-checking testbench for infix_to_postfix_converter_unit: a shunting-yard mirror
// predicts the postfix words, and a scoreboard checks every result word in order.
// Depends on itp_pkg and the converter RTL.
module infix_to_postfix_converter_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STACK_DEPTH  = 32;
  localparam int IDLE_LIMIT   = 3000;
  localparam int DRAIN_CYCLES = 150;

  typedef struct packed {
    logic [7:0] ch;
    logic       valid;
    logic       ovf;
    logic       last;
  } postfix_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } expr_char_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_char = 8'h00;
  logic       in_eoe = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_char;
  logic       out_char_valid;
  logic       out_overflow;
  logic       out_last;

  infix_to_postfix_converter_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_char(in_char),
    .in_end_of_expression(in_eoe),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char(out_char),
    .out_char_valid(out_char_valid),
    .out_overflow(out_overflow),
    .out_last(out_last)
  );

  function automatic bit is_blank_code(logic [7:0] c);
    return c == itp_pkg::CH_SPACE || (c >= itp_pkg::CH_TAB && c <= itp_pkg::CH_CR);
  endfunction

  function automatic bit is_operand_code(logic [7:0] c);
    return (c >= itp_pkg::CH_DIG_0 && c <= itp_pkg::CH_DIG_9) ||
           (c >= itp_pkg::CH_UP_A && c <= itp_pkg::CH_UP_Z) ||
           (c >= itp_pkg::CH_LO_A && c <= itp_pkg::CH_LO_Z);
  endfunction

  function automatic logic [1:0] op_rank(logic [7:0] c);
    if (c == itp_pkg::CH_PLUS || c == itp_pkg::CH_MINUS) return itp_pkg::PRIO_ADD;
    if (c == itp_pkg::CH_STAR || c == itp_pkg::CH_SLASH) return itp_pkg::PRIO_MUL;
    return itp_pkg::PRIO_NONE;
  endfunction

  class postfix_scoreboard;
    logic [7:0]    held_ops [STACK_DEPTH];
    int            held_count;
    int            produced;
    int            errors;
    postfix_word_t expected_words [$];

    function new();
      held_count = 0;
      errors = 0;
    endfunction

    function void emit(logic [7:0] c, logic v, logic o);
      postfix_word_t w;
      w.ch = c;
      w.valid = v;
      w.ovf = o;
      w.last = 1'b0;
      expected_words.push_back(w);
      produced++;
    endfunction

    function void pop_op();
      held_count--;
      emit(held_ops[held_count], 1'b1, 1'b0);
    endfunction

    function void push_op(logic [7:0] c);
      if (held_count >= STACK_DEPTH) begin
        emit(8'h00, 1'b0, 1'b1);
      end else begin
        held_ops[held_count] = c;
        held_count++;
      end
    endfunction

    // Works out the words released by one accepted character.
    function void note_char(logic [7:0] c, logic fin);
      logic [1:0] p;
      produced = 0;
      if (is_blank_code(c)) begin
        // skipped
      end else if (is_operand_code(c)) begin
        emit(c, 1'b1, 1'b0);
      end else if (c == itp_pkg::CH_OPEN) begin
        push_op(c);
      end else if (c == itp_pkg::CH_CLOSE) begin
        while (held_count > 0 && held_ops[held_count - 1] != itp_pkg::CH_OPEN) pop_op();
        if (held_count > 0) held_count--;
      end else begin
        p = op_rank(c);
        while (held_count > 0 && op_rank(held_ops[held_count - 1]) >= p) pop_op();
        push_op(c);
      end
      if (fin) begin
        while (held_count > 0) pop_op();
        if (produced == 0) emit(8'h00, 1'b0, 1'b0);
        expected_words[expected_words.size() - 1].last = 1'b1;
      end
    endfunction

    task report_mismatch(string what);
      errors++;
      $display("%0t ns: mismatch: %s", $time, what);
    endtask

    task check_word(postfix_word_t got);
      postfix_word_t want;
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word char=%h valid=%b ovf=%b last=%b",
                                  got.ch, got.valid, got.ovf, got.last));
        return;
      end
      want = expected_words.pop_front();
      if (got.ch !== want.ch || got.valid !== want.valid || got.ovf !== want.ovf ||
          got.last !== want.last)
        report_mismatch($sformatf("char %h/%h valid %b/%b ovf %b/%b last %b/%b (got/exp)",
                                  got.ch, want.ch, got.valid, want.valid,
                                  got.ovf, want.ovf, got.last, want.last));
    endtask
  endclass

  postfix_scoreboard sb;
  expr_char_t        script [$];
  int                send_idle_pct = 0;
  int                recv_idle_pct = 0;
  int                sent_words = 0;
  int                stalled = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Receiver back-pressure.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        sb.check_word('{out_char, out_char_valid, out_overflow, out_last});
      if (in_valid && in_ready) sb.note_char(in_char, in_eoe);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stalled = 0;
      else stalled++;
      if (stalled >= IDLE_LIMIT) begin
        $display("%0t ns: watchdog: no word moved for %0d cycles", $time, IDLE_LIMIT);
        $display("** infix_to_postfix_converter_unit: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_word(logic [7:0] c, logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_char <= c;
    in_eoe <= fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic play_script();
    foreach (script[i]) begin
      send_word(script[i].ch, script[i].fin);
      sent_words++;
    end
    script.delete();
  endtask

  function automatic void put_raw(logic [7:0] c, logic fin);
    expr_char_t e;
    e.ch = c;
    e.fin = fin;
    script.push_back(e);
  endfunction

  function automatic logic [7:0] blank_code();
    if ($urandom_range(3) == 0) return itp_pkg::CH_SPACE;
    return 8'($urandom_range(itp_pkg::CH_CR, itp_pkg::CH_TAB));
  endfunction

  function automatic logic [7:0] operand_code();
    case ($urandom_range(2))
      0: return 8'($urandom_range(itp_pkg::CH_DIG_9, itp_pkg::CH_DIG_0));
      1: return 8'($urandom_range(itp_pkg::CH_UP_Z, itp_pkg::CH_UP_A));
      default: return 8'($urandom_range(itp_pkg::CH_LO_Z, itp_pkg::CH_LO_A));
    endcase
  endfunction

  function automatic logic [7:0] operator_code();
    case ($urandom_range(3))
      0: return itp_pkg::CH_PLUS;
      1: return itp_pkg::CH_MINUS;
      2: return itp_pkg::CH_STAR;
      default: return itp_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic void put(logic [7:0] c);
    if ($urandom_range(7) == 0) put_raw(blank_code(), 1'b0);
    put_raw(c, 1'b0);
  endfunction

  function automatic void add_operand(int lvl);
    if (lvl < 3 && $urandom_range(3) == 0) begin
      put(itp_pkg::CH_OPEN);
      add_expr(lvl + 1);
      put(itp_pkg::CH_CLOSE);
    end else begin
      put(operand_code());
    end
  endfunction

  function automatic void add_expr(int lvl);
    add_operand(lvl);
    repeat ($urandom_range(4)) begin
      put(operator_code());
      add_operand(lvl);
    end
  endfunction

  // One expression: mostly well formed, some broken, some raw noise, a few deep nests
  // that can run the stack past full.
  function automatic void build_sequence();
    int kind;
    int idx;
    expr_char_t e;
    kind = $urandom_range(99);
    if (kind < 70) begin
      add_expr(0);
      if ($urandom_range(9) == 0) put_raw(blank_code(), 1'b0);
    end else if (kind < 82) begin
      add_expr(0);
      idx = $urandom_range(script.size() - 1);
      case ($urandom_range(3))
        0: script.delete(idx);
        1: script[idx].ch = 8'($urandom_range(255));
        2: put_raw(itp_pkg::CH_CLOSE, 1'b0);
        default: begin
          e.ch = itp_pkg::CH_OPEN;
          e.fin = 1'b0;
          script.insert(idx, e);
        end
      endcase
      if (script.size() == 0) put_raw(operand_code(), 1'b0);
    end else if (kind < 94) begin
      repeat ($urandom_range(12, 3)) put_raw(8'($urandom_range(255)), $urandom_range(7) == 0);
      return;
    end else begin
      repeat ($urandom_range(40, 28)) put_raw(itp_pkg::CH_OPEN, 1'b0);
      add_expr(2);
      repeat ($urandom_range(8)) put_raw(itp_pkg::CH_CLOSE, 1'b0);
    end
    script[script.size() - 1].fin = 1'b1;
  endfunction

  task automatic play_until(int target);
    while (sent_words < target) begin
      build_sequence();
      play_script();
    end
  endtask

  task automatic run_directed();
    // all four operators, nesting, precedence and a closing flush
    put_raw(itp_pkg::CH_LO_A, 1'b0);
    put_raw(itp_pkg::CH_PLUS, 1'b0);
    put_raw(itp_pkg::CH_LO_A + 8'd1, 1'b0);
    put_raw(itp_pkg::CH_STAR, 1'b0);
    put_raw(itp_pkg::CH_OPEN, 1'b0);
    put_raw(itp_pkg::CH_LO_A + 8'd2, 1'b0);
    put_raw(itp_pkg::CH_MINUS, 1'b0);
    put_raw(itp_pkg::CH_DIG_9, 1'b0);
    put_raw(itp_pkg::CH_CLOSE, 1'b0);
    put_raw(itp_pkg::CH_SLASH, 1'b0);
    put_raw(itp_pkg::CH_UP_Z, 1'b1);
    // unmatched close on an empty stack: only the bare last mark
    put_raw(itp_pkg::CH_CLOSE, 1'b1);
    // unknown codes at both ends of the range, whitespace around them
    put_raw(8'hFF, 1'b0);
    put_raw(itp_pkg::CH_TAB, 1'b0);
    put_raw(8'h00, 1'b0);
    put_raw(itp_pkg::CH_SPACE, 1'b1);
    put_raw(itp_pkg::CH_CR, 1'b1);
    // stray open paren gets flushed with the operator above it
    put_raw(itp_pkg::CH_OPEN, 1'b0);
    put_raw(itp_pkg::CH_LO_Z, 1'b0);
    put_raw(itp_pkg::CH_PLUS, 1'b0);
    put_raw(itp_pkg::CH_DIG_0, 1'b1);
    put_raw(8'h80, 1'b0);
    put_raw(8'h7F, 1'b0);
    put_raw(itp_pkg::CH_UP_A, 1'b0);
    put_raw(itp_pkg::CH_CLOSE, 1'b1);
    play_script();
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 34;
    recv_idle_pct = 50;
    run_directed();
    play_until(123);

    send_idle_pct = 50;
    recv_idle_pct = 34;
    play_until(246);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    play_until(370);

    in_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("** infix_to_postfix_converter_unit: PASSED **");
    else $display("** infix_to_postfix_converter_unit: FAILED **");
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/itp_pkg.sv
hw/rtl/itp_ram.sv
hw/rtl/itp_classify.sv
hw/rtl/infix_to_postfix_converter_unit.sv
tb/infix_to_postfix_converter_unit_tb.sv
